// ===== hdl/tae_pkg.sv =====
// types, constants and lookup functions for the thumb to arm expander
// no dependencies; used by thumb_to_arm_expander
`default_nettype none

package tae_pkg;

   // instruction classes that the decoder resolves
   typedef enum logic [4:0] {
      CLS_NONE    = 5'd0,
      CLS_SHIFT   = 5'd1,
      CLS_ADDSUB  = 5'd2,
      CLS_IMM     = 5'd3,
      CLS_ALU     = 5'd4,
      CLS_HIREG   = 5'd5,
      CLS_PCLOAD  = 5'd6,
      CLS_LSREG   = 5'd7,
      CLS_LSSIGN  = 5'd8,
      CLS_LSIMM   = 5'd9,
      CLS_LSHALF  = 5'd10,
      CLS_SPLS    = 5'd11,
      CLS_LADDR   = 5'd12,
      CLS_SPADJ   = 5'd13,
      CLS_PUSHPOP = 5'd14,
      CLS_MULTI   = 5'd15,
      CLS_BCOND   = 5'd16,
      CLS_SWI     = 5'd17,
      CLS_BRANCH  = 5'd18,
      CLS_LONGBL  = 5'd19
   } class_type;

   // base opcodes of the expanded words
   localparam logic [31:0] ARM_SHIFT   = 32'hE1B0_0000;
   localparam logic [31:0] ARM_SHREG   = 32'hE1B0_0010;
   localparam logic [31:0] ARM_DP      = 32'hE010_0000;
   localparam logic [31:0] ARM_DPIMM   = 32'hE210_0000;
   localparam logic [31:0] ARM_MUL     = 32'hE010_0090;
   localparam logic [31:0] ARM_HI_ADD  = 32'hE080_0000;
   localparam logic [31:0] ARM_HI_CMP  = 32'hE150_0000;
   localparam logic [31:0] ARM_HI_MOV  = 32'hE1A0_0000;
   localparam logic [31:0] ARM_BX      = 32'hE12F_FF10;
   localparam logic [31:0] ARM_PCLOAD  = 32'hE59F_0000;
   localparam logic [31:0] ARM_LSREG   = 32'hE780_0000;
   localparam logic [31:0] ARM_LSSIGN  = 32'hE180_0090;
   localparam logic [31:0] ARM_LSIMM   = 32'hE580_0000;
   localparam logic [31:0] ARM_LSHALF  = 32'hE1C0_00B0;
   localparam logic [31:0] ARM_SPLS    = 32'hE58D_0000;
   localparam logic [31:0] ARM_LADDR   = 32'hE280_0000;
   localparam logic [31:0] ARM_SPADJ   = 32'hE20D_D000;
   localparam logic [31:0] ARM_PUSHPOP = 32'hE80D_0000;
   localparam logic [31:0] ARM_MULTI   = 32'hE8A0_0000;
   localparam logic [31:0] ARM_BCOND   = 32'h0A00_0000;
   localparam logic [31:0] ARM_SWI     = 32'hEF00_0000;
   localparam logic [31:0] ARM_BRANCH  = 32'hEA00_0000;
   localparam logic [23:0] BRANCH_SEXT = 24'hFF_FC00;
   localparam logic [7:0]  PUSH_FLAGS  = 8'h12;
   localparam logic [7:0]  POP_FLAGS   = 8'h0B;
   localparam logic [3:0]  REG_SP      = 4'd13;
   localparam logic [3:0]  REG_PC      = 4'd15;

   // arm data-processing opcode for each thumb alu operation
   function automatic logic [3:0] alu_dp_op(input logic [3:0] op);
      logic [3:0] r;
      case (op)
         4'd0:    r = 4'h0;
         4'd1:    r = 4'h1;
         4'd5:    r = 4'h5;
         4'd6:    r = 4'h6;
         4'd8:    r = 4'h8;
         4'd9:    r = 4'h3;
         4'd10:   r = 4'hA;
         4'd11:   r = 4'hB;
         4'd12:   r = 4'hC;
         4'd13:   r = 4'h0;
         4'd14:   r = 4'hE;
         4'd15:   r = 4'hF;
         default: r = 4'hD;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] imm_dp_op(input logic [1:0] op);
      logic [3:0] r;
      case (op)
         2'd0:    r = 4'hD;
         2'd1:    r = 4'hA;
         2'd2:    r = 4'h4;
         default: r = 4'h2;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] half_sel(input logic [1:0] sel);
      logic [31:0] r;
      case (sel)
         2'd0:    r = 32'h0000_0020;
         2'd1:    r = 32'h0010_0020;
         2'd2:    r = 32'h0010_0040;
         default: r = 32'h0010_0060;
      endcase
      return r;
   endfunction

   // rotated immediate equal to imm8 * 4
   function automatic logic [11:0] scaled_imm(input logic [7:0] imm8);
      logic [11:0] r;
      if (imm8 < 8'd64) begin
         r = {2'b00, imm8, 2'b00};
      end else begin
         r = {4'hF, imm8};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/thumb_to_arm_expander.sv =====
// thumb to arm expander: input register, decode and remap, result register
// s1_word_ff holds input, s2_word_ff result; one word per cycle if no stall
// the decode and bit remap sit between the two registers in a single pass
// stall on the result side backs up through both stages without loss
// synchronous active-high reset empties both stages; payload is not reset
// depends on tae_pkg
`default_nettype none

module thumb_to_arm_expander (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_thumb_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_arm_word,
   output logic             rsp_translated
);

   logic        s1_valid_ff, s1_valid_in;
   logic [15:0] s1_word_ff;
   logic        s2_valid_ff, s2_valid_in;
   logic [31:0] s2_word_ff;
   logic        s2_ok_ff;
   logic        s1_adv;
   logic        s2_free;

   tae_pkg::class_type cls;
   logic [31:0] arm;
   logic        ok;

   // decode fields of the held word
   logic [15:0] w;
   logic [2:0]  rd, rs, r8, ro;
   logic [4:0]  imm5;
   logic [7:0]  imm8;
   logic [31:0] ld;
   logic [3:0]  alu_op;
   logic [1:0]  imm_op;
   logic [3:0]  hd, hs;
   logic [6:0]  ls_off;
   logic [5:0]  half_off;
   logic [11:0] br_off;

   // handshake
   always_comb begin
      s2_free     = !s2_valid_ff || !rsp_stall;
      s1_adv      = !s1_valid_ff || s2_free;
      req_stall   = !s1_adv;
      s1_valid_in = s1_adv ? req_valid : s1_valid_ff;
      s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && req_valid) begin
         s1_word_ff <= req_thumb_word;
      end
      if (s2_free && s1_valid_ff) begin
         s2_word_ff <= arm;
         s2_ok_ff   <= ok;
      end
   end

   // classify, most specific masks first
   always_comb begin
      w = s1_word_ff;
      if      ((w & 16'hFF00) == 16'hB000) cls = tae_pkg::CLS_SPADJ;
      else if ((w & 16'hFF00) == 16'hDF00) cls = tae_pkg::CLS_SWI;
      else if ((w & 16'hFC00) == 16'h4000) cls = tae_pkg::CLS_ALU;
      else if ((w & 16'hFC00) == 16'h4400) cls = tae_pkg::CLS_HIREG;
      else if ((w & 16'hF800) == 16'h1800) cls = tae_pkg::CLS_ADDSUB;
      else if ((w & 16'hF800) == 16'h4800) cls = tae_pkg::CLS_PCLOAD;
      else if ((w & 16'hF800) == 16'hE000) cls = tae_pkg::CLS_BRANCH;
      else if ((w & 16'hF800) == 16'hF000) cls = tae_pkg::CLS_LONGBL;
      else if ((w & 16'hF600) == 16'hB400) cls = tae_pkg::CLS_PUSHPOP;
      else if ((w & 16'hF200) == 16'h5000) cls = tae_pkg::CLS_LSREG;
      else if ((w & 16'hF200) == 16'h5200) cls = tae_pkg::CLS_LSSIGN;
      else if ((w & 16'hF000) == 16'h8000) cls = tae_pkg::CLS_LSHALF;
      else if ((w & 16'hF000) == 16'h9000) cls = tae_pkg::CLS_SPLS;
      else if ((w & 16'hF000) == 16'hA000) cls = tae_pkg::CLS_LADDR;
      else if ((w & 16'hF000) == 16'hC000) cls = tae_pkg::CLS_MULTI;
      else if ((w & 16'hF000) == 16'hD000) cls = tae_pkg::CLS_BCOND;
      else if ((w & 16'hE000) == 16'h0000) cls = tae_pkg::CLS_SHIFT;
      else if ((w & 16'hE000) == 16'h2000) cls = tae_pkg::CLS_IMM;
      else if ((w & 16'hE000) == 16'h6000) cls = tae_pkg::CLS_LSIMM;
      else                                 cls = tae_pkg::CLS_NONE;
   end

   // remap
   always_comb begin
      rd       = w[2:0];
      rs       = w[5:3];
      r8       = w[10:8];
      ro       = w[8:6];
      imm5     = w[10:6];
      imm8     = w[7:0];
      ld       = {11'd0, w[11], 20'd0};
      alu_op   = w[9:6];
      imm_op   = w[12:11];
      hd       = {w[7], rd};
      hs       = {w[6], rs};
      ls_off   = w[12] ? {2'b00, imm5} : {imm5, 2'b00};
      half_off = {imm5, 1'b0};
      br_off   = {w[10:0], 1'b0};
      ok       = 1'b1;
      arm      = 32'd0;
      case (cls)
         tae_pkg::CLS_SHIFT: begin
            arm = tae_pkg::ARM_SHIFT | (32'(rd) << 12) | 32'(rs) | (32'(imm5) << 7)
                | (32'(w[12:11]) << 5);
         end
         tae_pkg::CLS_ADDSUB: begin
            arm = tae_pkg::ARM_DP | (32'(w[10]) << 25)
                | ((w[9] ? 32'h2 : 32'h4) << 21) | (32'(rs) << 16) | (32'(rd) << 12)
                | 32'(ro);
         end
         tae_pkg::CLS_IMM: begin
            arm = tae_pkg::ARM_DPIMM | (32'(tae_pkg::imm_dp_op(imm_op)) << 21)
                | ((imm_op != 2'd0) ? (32'(r8) << 16) : 32'd0)
                | ((imm_op != 2'd1) ? (32'(r8) << 12) : 32'd0) | 32'(imm8);
         end
         tae_pkg::CLS_ALU: begin
            case (alu_op) inside
               4'd2, 4'd3, 4'd4, 4'd7: begin
                  // register-specified shift, rd shifted by rs
                  arm = tae_pkg::ARM_SHREG
                      | (32'((alu_op == 4'd7) ? 2'd3 : 2'(alu_op - 4'd2)) << 5)
                      | (32'(rs) << 8) | (32'(rd) << 12) | 32'(rd);
               end
               4'd8, 4'd10, 4'd11: begin
                  arm = tae_pkg::ARM_DP | (32'(tae_pkg::alu_dp_op(alu_op)) << 21)
                      | (32'(rd) << 16) | 32'(rs);
               end
               4'd9: begin
                  // negate as reverse subtract from zero
                  arm = tae_pkg::ARM_DP | (32'(tae_pkg::alu_dp_op(alu_op)) << 21)
                      | (32'd1 << 25) | (32'(rs) << 16) | (32'(rd) << 12);
               end
               4'd15: begin
                  arm = tae_pkg::ARM_DP | (32'(tae_pkg::alu_dp_op(alu_op)) << 21)
                      | (32'(rd) << 12) | 32'(rs);
               end
               4'd13: begin
                  arm = tae_pkg::ARM_MUL | (32'(rd) << 16) | (32'(rd) << 8) | 32'(rs);
               end
               default: begin
                  arm = tae_pkg::ARM_DP | (32'(tae_pkg::alu_dp_op(alu_op)) << 21)
                      | (32'(rd) << 16) | (32'(rd) << 12) | 32'(rs);
               end
            endcase
         end
         tae_pkg::CLS_HIREG: begin
            case (w[9:8])
               2'd0: arm = tae_pkg::ARM_HI_ADD | (32'(hd) << 16) | (32'(hd) << 12)
                         | 32'(hs);
               2'd1: arm = tae_pkg::ARM_HI_CMP | (32'(hd) << 16) | 32'(hs);
               2'd2: arm = tae_pkg::ARM_HI_MOV | (32'(hd) << 12) | 32'(hs);
               default: arm = tae_pkg::ARM_BX | 32'(hs);
            endcase
         end
         tae_pkg::CLS_PCLOAD: begin
            arm = tae_pkg::ARM_PCLOAD | (32'(r8) << 12) | (32'(imm8) << 2);
         end
         tae_pkg::CLS_LSREG: begin
            arm = tae_pkg::ARM_LSREG | ld | (32'(w[10]) << 22) | (32'(rs) << 16)
                | (32'(rd) << 12) | 32'(ro);
         end
         tae_pkg::CLS_LSSIGN: begin
            arm = tae_pkg::ARM_LSSIGN | (32'(rs) << 16) | (32'(rd) << 12) | 32'(ro)
                | tae_pkg::half_sel({w[10], w[11]});
         end
         tae_pkg::CLS_LSIMM: begin
            arm = tae_pkg::ARM_LSIMM | (32'(rs) << 16) | (32'(rd) << 12) | ld
                | (32'(w[12]) << 22) | 32'(ls_off);
         end
         tae_pkg::CLS_LSHALF: begin
            arm = tae_pkg::ARM_LSHALF | (32'(rs) << 16) | (32'(rd) << 12) | ld
                | (32'(half_off[5:4]) << 8) | 32'(half_off[3:0]);
         end
         tae_pkg::CLS_SPLS: begin
            arm = tae_pkg::ARM_SPLS | (32'(r8) << 12) | ld | (32'(imm8) << 2);
         end
         tae_pkg::CLS_LADDR: begin
            arm = tae_pkg::ARM_LADDR
                | (32'(w[11] ? tae_pkg::REG_SP : tae_pkg::REG_PC) << 16)
                | (32'(r8) << 12) | 32'(tae_pkg::scaled_imm(imm8));
         end
         tae_pkg::CLS_SPADJ: begin
            arm = tae_pkg::ARM_SPADJ | ((w[7] ? 32'h2 : 32'h4) << 21)
                | 32'(tae_pkg::scaled_imm({1'b0, w[6:0]}));
         end
         tae_pkg::CLS_PUSHPOP: begin
            arm = tae_pkg::ARM_PUSHPOP
                | (32'(w[11] ? tae_pkg::POP_FLAGS : tae_pkg::PUSH_FLAGS) << 20)
                | (w[8] ? (w[11] ? 32'h8000 : 32'h4000) : 32'd0) | 32'(imm8);
         end
         tae_pkg::CLS_MULTI: begin
            arm = tae_pkg::ARM_MULTI | ld | (32'(r8) << 16) | 32'(imm8);
         end
         tae_pkg::CLS_BCOND: begin
            arm = tae_pkg::ARM_BCOND | (32'(w[11:8]) << 28)
                | {8'd0, {15{imm8[7]}}, imm8, 1'b0};
         end
         tae_pkg::CLS_SWI: begin
            arm = tae_pkg::ARM_SWI | 32'(imm8);
         end
         tae_pkg::CLS_BRANCH: begin
            arm = tae_pkg::ARM_BRANCH | 32'(br_off)
                | (br_off[11] ? {8'd0, tae_pkg::BRANCH_SEXT} : 32'd0);
         end
         default: begin
            // long branch with link and unmatched words
            ok  = 1'b0;
            arm = 32'd0;
         end
      endcase
   end

   assign rsp_valid      = s2_valid_ff;
   assign rsp_arm_word   = s2_word_ff;
   assign rsp_translated = s2_ok_ff;

`ifndef NO_ASSERTIONS
   a_untranslated_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_translated |-> rsp_arm_word == 32'd0)
      else $error("untranslated word is not zero");

   a_cond_never_nv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_translated |-> rsp_arm_word[31:28] != 4'hF)
      else $error("expanded word carries condition 1111");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff && rsp_stall)
      else $error("input stalled while pipeline has room");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_valid_ff)
      else $error("accepted word lost from input stage");

   a_held_word: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> $stable(s1_word_ff) && s1_valid_ff)
      else $error("waiting input word changed");
`endif

endmodule

`default_nettype wire
